[sv/servo_trajectory_interpolator_assert.svh]
// ----------------------------------------------------------------------------
// Servo trajectory interpolator assertion macros
// Shared property forms for the interpolator and its serial arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef SERVO_TRAJECTORY_INTERPOLATOR_ASSERT_SVH
`define SERVO_TRAJECTORY_INTERPOLATOR_ASSERT_SVH

// Condition holds at every edge out of reset.
`define STI_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define STI_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define STI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/sti_pkg.sv]
// ----------------------------------------------------------------------------
// Servo trajectory interpolator package
// Field widths and the request/response bundles of the serial mul/div unit.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int ANG_W  = 15;  // angle, 1/64 degree, signed
  localparam int DUR_W  = 16;  // move duration, ms
  localparam int TIME_W = 32;  // free-running time, ms
  localparam int ID_W   = 8;   // servo id on the input side
  localparam int OID_W  = 5;   // servo id on the output side

  // item kinds on the input side
  typedef enum logic [0:0] {
    SET_TARGET = 1'b0,
    TICK       = 1'b1
  } servo_cmd_t;

  typedef struct packed {
    logic             start;
    logic [DUR_W-1:0] mcand;    // |goal - start|
    logic [DUR_W-1:0] mplier;   // elapsed time, below the duration
    logic [DUR_W-1:0] divisor;  // move duration
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [DUR_W-1:0] quot;
  } md_rsp_t;

endpackage

[sv/servo_trajectory_interpolator.sv]
// A set-target item is stored, or its result registered, in the set state
// after it is accepted, and the input is ready again once that is done.
// A tick scans the channels in order; each active channel is compared and,
// unless it has landed, goes through 16 multiply steps and 16 divide steps
// in the serial unit before it is emitted; one item at a time.
// Reset clears all channels to angle zero and inactive, output empty.
// ----------------------------------------------------------------------------
// Servo trajectory interpolator
// Per-channel linear moves from the current angle to a target over a duration.
// ----------------------------------------------------------------------------
module servo_trajectory_interpolator
  import sti_pkg::*;
#(
  parameter int NUM_SERVOS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // servo_id, target_angle, duration_ms, now_ms
  input  logic [0:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // servo_id_out, angle_out
  output logic [0:0]  m_axis_tuser,   // finished
  output logic        m_axis_tlast
);

  localparam int CH_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_SERVOS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SET  = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]            state;
  logic [CH_W-1:0]       ch;
  logic [NUM_SERVOS-1:0] active;
  logic [NUM_SERVOS-1:0] pend;
  logic [ANG_W-1:0]      current_angle [NUM_SERVOS];
  logic [ANG_W-1:0]      start_angle   [NUM_SERVOS];
  logic [ANG_W-1:0]      goal_angle    [NUM_SERVOS];
  logic [TIME_W-1:0]     start_time    [NUM_SERVOS];
  logic [DUR_W-1:0]      move_duration [NUM_SERVOS];

  logic [ID_W-1:0]   id_r;
  logic [ANG_W-1:0]  tgt_r;
  logic [DUR_W-1:0]  dur_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] elapsed;
  logic              neg;
  logic [ANG_W-1:0]  res_angle;
  logic              res_fin;

  logic              out_valid;
  logic [OID_W-1:0]  out_id;
  logic [ANG_W-1:0]  out_angle;
  logic              out_fin;
  logic              out_last;

  md_req_t md_req;
  md_rsp_t md_rsp;

  logic                  in_acc;
  logic                  out_free;
  logic                  id_ok;
  logic [CH_W-1:0]       id_idx;
  logic [NUM_SERVOS-1:0] chan_bit;
  logic                  is_last;
  logic                  set_now;
  logic                  set_sched;
  logic                  emit;
  logic                  land;
  logic [DUR_W-1:0]      diff;
  logic [DUR_W-1:0]      diff_mag;
  logic [DUR_W-1:0]      q_signed;
  logic [DUR_W-1:0]      interp;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign id_ok         = {1'b0, id_r} < (ID_W + 1)'(NUM_SERVOS);
  assign id_idx        = id_r[CH_W-1:0];
  assign chan_bit      = NUM_SERVOS'(1) << ch;
  assign is_last       = (pend & ~chan_bit) == '0;
  assign set_now       = (state == ST_SET) && id_ok && (dur_r == '0) && out_free;
  assign set_sched     = (state == ST_SET) && id_ok && (dur_r != '0);
  assign emit          = (state == ST_EMIT) && out_free;
  assign land          = (elapsed >= {{(TIME_W - DUR_W){1'b0}}, move_duration[ch]})
                         || (move_duration[ch] == '0);

  assign diff     = {goal_angle[ch][ANG_W-1], goal_angle[ch]}
                    - {start_angle[ch][ANG_W-1], start_angle[ch]};
  assign diff_mag = diff[DUR_W-1] ? -diff : diff;
  assign q_signed = neg ? -md_rsp.quot : md_rsp.quot;
  assign interp   = {start_angle[ch][ANG_W-1], start_angle[ch]} + q_signed;

  assign md_req.start   = (state == ST_CMP) && !land;
  assign md_req.mcand   = diff_mag;
  assign md_req.mplier  = elapsed[DUR_W-1:0];
  assign md_req.divisor = move_duration[ch];

  sti_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // control, channel flags and current angles
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ch        <= '0;
      active    <= '0;
      pend      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        current_angle[i] <= '0;
      end
    end else begin
      if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            ch <= '0;
            if (s_axis_tuser[0] == TICK) begin
              pend  <= active;
              state <= ST_SCAN;
            end else begin
              state <= ST_SET;
            end
          end
        end
        ST_SET: begin
          if (!id_ok) begin
            state <= ST_IDLE;
          end else if (dur_r != '0) begin
            active[id_idx] <= 1'b1;
            state          <= ST_IDLE;
          end else if (out_free) begin
            current_angle[id_idx] <= tgt_r;
            active[id_idx]        <= 1'b0;
            out_valid             <= 1'b1;
            state                 <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (pend[ch]) begin
            state <= ST_CMP;
          end else if (ch == CH_LAST) begin
            state <= ST_IDLE;
          end else begin
            ch <= ch + 1'b1;
          end
        end
        ST_CMP: begin
          state <= land ? ST_EMIT : ST_WAIT;
        end
        ST_WAIT: begin
          if (md_rsp.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            current_angle[ch] <= res_angle;
            if (res_fin) begin
              active[ch] <= 1'b0;
            end
            pend[ch]  <= 1'b0;
            out_valid <= 1'b1;
            if (is_last || ch == CH_LAST) begin
              state <= ST_IDLE;
            end else begin
              ch    <= ch + 1'b1;
              state <= ST_SCAN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // move records, latched item and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r  <= s_axis_tdata[7:0];
      tgt_r <= s_axis_tdata[22:8];
      dur_r <= s_axis_tdata[38:23];
      now_r <= s_axis_tdata[70:39];
    end
    if (set_sched) begin
      start_angle[id_idx]   <= current_angle[id_idx];
      goal_angle[id_idx]    <= tgt_r;
      start_time[id_idx]    <= now_r;
      move_duration[id_idx] <= dur_r;
    end
    if (state == ST_SCAN) begin
      elapsed <= now_r - start_time[ch];
    end
    if (state == ST_CMP) begin
      neg       <= diff[DUR_W-1];
      res_angle <= goal_angle[ch];
      res_fin   <= land;
    end
    if (state == ST_WAIT && md_rsp.done) begin
      res_angle <= interp[ANG_W-1:0];
    end
    if (set_now) begin
      out_id    <= id_r[OID_W-1:0];
      out_angle <= tgt_r;
      out_fin   <= 1'b1;
      out_last  <= 1'b1;
    end else if (emit) begin
      out_id    <= OID_W'(ch);
      out_angle <= res_angle;
      out_fin   <= res_fin;
      out_last  <= is_last;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = {4'b0000, out_angle, out_id};
  assign m_axis_tuser[0] = out_fin;
  assign m_axis_tlast    = out_last;

`include "servo_trajectory_interpolator_assert.svh"

  `STI_ASSERT_ALWAYS(a_pend_active, clk, rst, (pend & ~active) == '0, "pending channel not active")
  `STI_ASSERT_NEXT(a_last_idle, clk, rst, emit && is_last, state == ST_IDLE, "walk continued after last")
  `STI_ASSERT_SAME(a_wait_start, clk, rst, md_req.start, state == ST_CMP && active[ch], "divide on idle channel")

endmodule

[sv/sti_muldiv.sv]
// ----------------------------------------------------------------------------
// Serial multiply-divide unit
// Computes (mcand * mplier) / divisor one bit per cycle: 16 shift-add steps,
// then 16 restoring-division steps on the same shift register.
// ----------------------------------------------------------------------------
module sti_muldiv
  import sti_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);

  localparam int        CNT_W    = $clog2(DUR_W);
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]       phase;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [DUR_W:0]   rem;      // high half of the product, then remainder
  logic [DUR_W-1:0] quo;      // low half of the product, then quotient
  logic [DUR_W-1:0] mcand;
  logic [DUR_W-1:0] divisor;

  logic [DUR_W:0]   sum;
  logic [DUR_W:0]   trial;
  logic             fits;

  assign sum   = rem + (quo[0] ? {1'b0, mcand} : '0);
  assign trial = {rem[DUR_W-1:0], quo[DUR_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (req.start) begin
            phase <= PH_MUL;
            cnt   <= '0;
          end
        end
        PH_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DUR_W - 1)) begin
            phase <= PH_DIV;
          end
        end
        PH_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DUR_W - 1)) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      PH_IDLE: begin
        if (req.start) begin
          rem     <= '0;
          quo     <= req.mplier;
          mcand   <= req.mcand;
          divisor <= req.divisor;
        end
      end
      PH_MUL: begin
        // add and shift the product right by one
        rem <= {1'b0, sum[DUR_W:1]};
        quo <= {sum[0], quo[DUR_W-1:1]};
      end
      PH_DIV: begin
        // shift in the next dividend bit, subtract when it fits
        rem <= fits ? (trial - {1'b0, divisor}) : trial;
        quo <= {quo[DUR_W-2:0], fits};
      end
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

`include "servo_trajectory_interpolator_assert.svh"

  `STI_ASSERT_SAME(a_start_idle, clk, rst, req.start, phase == PH_IDLE, "start while busy")
  `STI_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done longer than one cycle")
  `STI_ASSERT_SAME(a_rem_bound, clk, rst, phase == PH_DIV, rem < {1'b0, divisor}, "remainder out of range")

endmodule

[dv/servo_trajectory_interpolator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo trajectory interpolator testbench
// Streams set-target and tick items into the interpolator and checks every
// angle it drives against a local per-channel move tracker, with random
// stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module servo_trajectory_interpolator_test
  import sti_pkg::*;
();

  localparam int CHANNELS   = 8;
  localparam int RAND_ITEMS = 400;
  localparam int TAIL_WAIT  = 400;
  localparam int HOLD_LEN   = 2000;
  localparam int CYCLE_CAP  = 1000000;

  typedef struct packed {
    servo_cmd_t              cmd;
    logic [ID_W-1:0]         id;
    logic signed [ANG_W-1:0] target;
    logic [DUR_W-1:0]        dur;
    logic [TIME_W-1:0]       now;
  } servo_req_t;

  typedef struct packed {
    logic [OID_W-1:0]        id;
    logic signed [ANG_W-1:0] angle;
    logic                    finished;
    logic                    last;
  } servo_drive_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;    // servo_id, target_angle, duration_ms, now_ms
  logic [0:0]  s_axis_tuser = '0;    // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // servo_id_out, angle_out
  logic [0:0]  m_axis_tuser;         // finished
  logic        m_axis_tlast;

  // move tracker state, one entry per channel
  logic signed [ANG_W-1:0] cur_ang  [CHANNELS];
  logic signed [ANG_W-1:0] st_ang   [CHANNELS];
  logic signed [ANG_W-1:0] goal_ang [CHANNELS];
  logic [TIME_W-1:0]       t0       [CHANNELS];
  logic [DUR_W-1:0]        dur_ms   [CHANNELS];
  bit                      moving   [CHANNELS];

  servo_req_t   req_backlog[$];
  servo_drive_t angle_cmds_due[$];
  servo_req_t   cur_req;

  int          total_items = 1;
  int          items_taken = 0;
  int          ticks_sent = 0;
  int          sets_sent = 0;
  int          drives_seen = 0;
  int          landings_seen = 0;
  int          errors = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycles_run = 0;

  servo_trajectory_interpolator #(
    .NUM_SERVOS(CHANNELS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // Per-cycle idle chance for each side, by how far the run has got.
  function automatic int idle_pct(input bit rx_side);
    int ph;
    ph = (items_taken * 3) / total_items;
    if (ph == 0) return rx_side ? 47 : 6;
    if (ph == 1) return rx_side ? 6 : 47;
    return 0;
  endfunction

  // Apply one accepted item to the move tracker and queue the angles it drives.
  task automatic servo_advance(input servo_req_t r);
    logic [TIME_W-1:0] elapsed;
    longint            span;
    longint            delta;
    servo_drive_t      d;
    int                last_ch;
    if (r.cmd == SET_TARGET) begin
      sets_sent++;
      if (r.id < CHANNELS) begin
        if (r.dur == 0) begin
          cur_ang[r.id] = r.target;
          moving[r.id] = 1'b0;
          d.id = r.id[OID_W-1:0];
          d.angle = r.target;
          d.finished = 1'b1;
          d.last = 1'b1;
          angle_cmds_due.push_back(d);
        end else begin
          moving[r.id] = 1'b1;
          st_ang[r.id] = cur_ang[r.id];
          goal_ang[r.id] = r.target;
          t0[r.id] = r.now;
          dur_ms[r.id] = r.dur;
        end
      end
    end else begin
      ticks_sent++;
      last_ch = -1;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (moving[ch]) last_ch = ch;
      end
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (moving[ch]) begin
          elapsed = r.now - t0[ch];
          if (elapsed >= dur_ms[ch] || dur_ms[ch] == 0) begin
            cur_ang[ch] = goal_ang[ch];
            moving[ch] = 1'b0;
            d.finished = 1'b1;
          end else begin
            span = longint'(goal_ang[ch]) - longint'(st_ang[ch]);
            delta = (span * longint'(elapsed)) / longint'(dur_ms[ch]);
            cur_ang[ch] = ANG_W'(longint'(st_ang[ch]) + delta);
            d.finished = 1'b0;
          end
          d.id = OID_W'(ch);
          d.angle = cur_ang[ch];
          d.last = (ch == last_ch);
          angle_cmds_due.push_back(d);
        end
      end
    end
  endtask

  task automatic add_req(input servo_cmd_t cmd, input logic [ID_W-1:0] id,
                         input logic signed [ANG_W-1:0] target,
                         input logic [DUR_W-1:0] dur, input logic [TIME_W-1:0] now);
    servo_req_t r;
    r.cmd = cmd;
    r.id = id;
    r.target = target;
    r.dur = dur;
    r.now = now;
    req_backlog.push_back(r);
  endtask

  // Driver: hold the item until taken, then maybe idle before the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        servo_advance(cur_req);
        items_taken <= items_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_backlog.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          cur_req = req_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, cur_req.now, cur_req.dur, cur_req.target, cur_req.id};
          s_axis_tuser <= cur_req.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off once, a quarter of the way in.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && items_taken >= total_items / 4) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each driven angle with the oldest one due.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (angle_cmds_due.size() == 0) begin
          $error("unexpected item: servo_id_out %0d angle_out %0d",
                 m_axis_tdata[4:0], $signed(m_axis_tdata[19:5]));
          errors++;
        end else begin
          servo_drive_t e;
          e = angle_cmds_due.pop_front();
          drives_seen++;
          if (e.finished) landings_seen++;
          if (m_axis_tdata[4:0] !== e.id) begin
            $error("servo_id_out: expected %0d, got %0d", e.id, m_axis_tdata[4:0]);
            errors++;
          end
          if (m_axis_tdata[19:5] !== e.angle) begin
            $error("angle_out: expected %0d, got %0d", e.angle, $signed(m_axis_tdata[19:5]));
            errors++;
          end
          if (m_axis_tuser[0] !== e.finished) begin
            $error("finished: expected %0d, got %0d", e.finished, m_axis_tuser[0]);
            errors++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
            errors++;
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run >= CYCLE_CAP) begin
      $display("servo_trajectory_interpolator_test: done, errors");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0] t_ms;
    int                counted;
    int                r;
    logic [DUR_W-1:0]  d;
    logic [ID_W-1:0]   id;

    for (int ch = 0; ch < CHANNELS; ch++) begin
      cur_ang[ch] = '0;
      st_ang[ch] = '0;
      goal_ang[ch] = '0;
      t0[ch] = '0;
      dur_ms[ch] = '0;
      moving[ch] = 1'b0;
    end

    // directed: idle tick, extremes, ignored ids, replace, wrap, late ticks
    add_req(TICK, 8'd0, 15'sd0, 16'd0, 32'd0);
    add_req(SET_TARGET, 8'd0, 15'sh3FFF, 16'd0, 32'd5);
    add_req(SET_TARGET, 8'd7, 15'sh4000, 16'd0, 32'd5);
    add_req(SET_TARGET, 8'd8, 15'sd100, 16'd0, 32'd5);
    add_req(SET_TARGET, 8'hFF, 15'sh7FFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_req(SET_TARGET, 8'd1, 15'sd11520, 16'd100, 32'd1000);
    add_req(SET_TARGET, 8'd2, -15'sd11520, 16'd1, 32'd1000);
    add_req(SET_TARGET, 8'd7, 15'sh3FFF, 16'hFFFF, 32'd1000);
    add_req(TICK, 8'hFF, 15'sh7FFF, 16'hFFFF, 32'd1050);
    add_req(SET_TARGET, 8'd1, -15'sd5000, 16'd200, 32'd1060);
    add_req(TICK, 8'd0, 15'sd0, 16'd0, 32'd1061);
    add_req(TICK, 8'd0, 15'sd0, 16'd0, 32'd1160);
    add_req(SET_TARGET, 8'd3, 15'sh2AAA, 16'hAAAA, 32'hFFFF_FF00);
    add_req(SET_TARGET, 8'd6, 15'sh5555, 16'h5555, 32'hFFFF_FFF0);
    add_req(TICK, 8'd0, 15'sd0, 16'd0, 32'h0000_0010);
    add_req(SET_TARGET, 8'd4, 15'sd50, 16'd10, 32'h8000_0000);
    add_req(TICK, 8'd0, 15'sd0, 16'd0, 32'h7FFF_FFFF);
    add_req(SET_TARGET, 8'd5, 15'sd0, 16'd0, 32'h7FFF_FFFF);
    add_req(TICK, 8'd0, 15'sd0, 16'd0, 32'hFFFF_FFFF);
    add_req(TICK, 8'd0, 15'sd0, 16'd0, 32'd0);

    // random: scheduled moves, immediate sets, dropped ids and ticks on a mostly steady clock
    t_ms = $urandom;
    counted = 0;
    while (counted < RAND_ITEMS) begin
      r = $urandom_range(99);
      if (r < 40) begin
        if ($urandom_range(99) < 4) t_ms = t_ms + $urandom;
        else t_ms = t_ms + $urandom_range(0, 40);
        add_req(TICK, ID_W'($urandom), ANG_W'($urandom), DUR_W'($urandom), t_ms);
        counted++;
      end else if (r < 80) begin
        case ($urandom_range(9))
          0, 1:    d = DUR_W'($urandom_range(1, 4));
          2:       d = DUR_W'($urandom_range(1, 65535));
          default: d = DUR_W'($urandom_range(1, 120));
        endcase
        add_req(SET_TARGET, ID_W'($urandom_range(0, CHANNELS - 1)),
                ($urandom_range(9) == 0) ? ANG_W'($urandom)
                                         : ANG_W'($signed($urandom_range(0, 23040)) - 11520),
                d, ($urandom_range(19) == 0) ? t_ms - $urandom_range(1, 20) : t_ms);
        counted++;
      end else if (r < 90) begin
        add_req(SET_TARGET, ID_W'($urandom_range(0, CHANNELS - 1)), ANG_W'($urandom),
                16'd0, $urandom);
        counted++;
      end else begin
        // drop: out-of-range channel
        id = ID_W'($urandom_range(CHANNELS, 255));
        add_req(SET_TARGET, id, ANG_W'($urandom), DUR_W'($urandom), $urandom);
        counted++;
      end
    end
    total_items = req_backlog.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (items_taken < total_items || angle_cmds_due.size() > 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("%0d items sent: %0d ticks, %0d set-targets", total_items, ticks_sent,
             sets_sent);
    $display("%0d drive items checked, %0d of them channel landings", drives_seen,
             landings_seen);
    if (errors == 0 && angle_cmds_due.size() == 0) begin
      $display("servo_trajectory_interpolator_test: done, clean");
    end else begin
      $display("servo_trajectory_interpolator_test: done, errors");
    end
    $finish;
  end

endmodule
